// ----- src/vld_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vld_pkg: shared types and constants of the varint length deframer
// Holds result status codes, length prefix codes and the record that the
// parser front hands to the formatting back through the queue.
// ============================================================================
package vld_pkg;

    // Width of the varint value field in its longest (4-byte) form
    localparam int VARINT_BITS = 30;
    localparam int CONSUMED_BITS = 31;
    localparam int QUEUE_DEPTH = 2;

    // Value bits carried by the first length byte
    localparam logic [7:0] VALUE_BITS_MASK = 8'h3f;
    localparam int PREFIX_SHIFT = 6;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_RESERVED   = 2'd1,
        ST_INCOMPLETE = 2'd2
    } status_t;

    // Top two bits of the first length byte
    localparam logic [1:0] PREFIX_ONE      = 2'b00;
    localparam logic [1:0] PREFIX_TWO      = 2'b01;
    localparam logic [1:0] PREFIX_FOUR     = 2'b10;
    localparam logic [1:0] PREFIX_FOUR_ALT = 2'b11;

    localparam logic [2:0] VSIZE_NONE = 3'd0;
    localparam logic [2:0] VSIZE_ONE  = 3'd1;
    localparam logic [2:0] VSIZE_TWO  = 3'd2;
    localparam logic [2:0] VSIZE_FOUR = 3'd4;

    // One classified item waiting to be turned into a result
    typedef struct packed {
        status_t                  status;
        logic                     has_data;
        logic [7:0]               data;
        logic [7:0]               flag;
        logic [VARINT_BITS-1:0]   len;
        logic [2:0]               vsize;
        logic                     len_known;
        logic                     last;
    } cmd_t;

endpackage

// ----- src/varint_length_deframer.sv -----
`timescale 1ns / 1ps
// Each result passes through a queue entry and then the output register.
// Throughput: one byte per cycle while the result queue is not full.
// Bytes keep flowing while up to two results wait behind a stalled consumer.
// Reset (rst_n low, asynchronous): parser hunts for a flag byte, queue and
// output are empty, flag_mask returns to 1.
// ============================================================================
// varint_length_deframer: splits a byte stream into length-prefixed frames
// Each frame is a flag byte, a varint payload length (1, 2 or 4 bytes) and
// the payload; every payload byte comes out tagged with its frame's fields.
// ============================================================================
module varint_length_deframer #(
    parameter int LENGTH_BITS = 30
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // flag mask register
    input  logic                              flag_mask_we,
    input  logic [7:0]                        flag_mask_data,
    // byte stream
    input  logic                              byte_valid,
    output logic                              byte_ready,
    input  logic [7:0]                        byte_in,
    input  logic                              buffer_end,
    // results
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [1:0]                        status,
    output logic                              has_data,
    output logic [7:0]                        data_out,
    output logic [7:0]                        frame_flag,
    output logic [vld_pkg::VARINT_BITS-1:0]   payload_length,
    output logic [vld_pkg::CONSUMED_BITS-1:0] consumed_length,
    output logic                              last
);
    import vld_pkg::*;

    logic [7:0] flag_mask_reg;

    // Front to queue
    logic       push;
    cmd_t       push_cmd;
    logic       queue_full;

    // Queue to back
    logic       head_valid;
    cmd_t       head_cmd;
    logic       pop;

    // Hold the allowed flag bits; the user must write them only while the block is idle (not enforced)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_mask_reg <= 8'd1;
        end
        else if (flag_mask_we)
        begin
            flag_mask_reg <= flag_mask_data;
        end
    end

    // Parse bytes and classify each into at most one result record
    vld_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .flag_mask  (flag_mask_reg),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_in    (byte_in),
        .buffer_end (buffer_end),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Decouple the parser from output stalls
    vld_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    // Fill in length fields and present each result from a register
    vld_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_cmd        (head_cmd),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .status          (status),
        .has_data        (has_data),
        .data_out        (data_out),
        .frame_flag      (frame_flag),
        .payload_length  (payload_length),
        .consumed_length (consumed_length),
        .last            (last)
    );

endmodule

// ----- src/vld_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vld_front: frame parser front end
// Accepts one stream byte per cycle while the queue has room, tracks the frame phase and pushes a
// result record into the queue whenever a byte produces a result.
// ============================================================================
module vld_front #(
    parameter int LENGTH_BITS = 30
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    flag_mask,
    input  logic          byte_valid,
    output logic          byte_ready,
    input  logic [7:0]    byte_in,
    input  logic          buffer_end,
    input  logic          queue_full,
    output logic          push,
    output vld_pkg::cmd_t cmd
);
    import vld_pkg::*;

    localparam logic [VARINT_BITS-1:0] MAX_LEN =
        VARINT_BITS'((64'd1 << LENGTH_BITS) - 64'd1);

    typedef enum logic [2:0] {
        PH_FLAG    = 3'b001,
        PH_LENGTH  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [7:0]              flag_reg, flag_next;
    logic [1:0]              left_reg, left_next;
    logic [VARINT_BITS-1:0]  acc_reg, acc_next;
    logic [LENGTH_BITS-1:0]  payload_left_reg, payload_left_next;
    logic [2:0]              vsize_reg, vsize_next;

    logic                    accept;
    logic [2:0]              vs_new;
    logic [1:0]              left_new;
    logic [VARINT_BITS-1:0]  acc_new;
    logic [VARINT_BITS-1:0]  acc_sat;
    logic                    fin;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;
    assign fin        = (payload_left_reg <= LENGTH_BITS'(1));

    // Length byte decode: first byte picks the form, later bytes shift in
    always_comb
    begin
        vs_new   = vsize_reg;
        left_new = left_reg - 2'd1;
        acc_new  = {acc_reg[VARINT_BITS-9:0], byte_in};
        if (vsize_reg == VSIZE_NONE)
        begin
            unique case (byte_in[7:PREFIX_SHIFT]) inside
                PREFIX_ONE:                  vs_new = VSIZE_ONE;
                PREFIX_TWO:                  vs_new = VSIZE_TWO;
                PREFIX_FOUR, PREFIX_FOUR_ALT: vs_new = VSIZE_FOUR;
            endcase
            left_new = 2'(vs_new - 3'd1);
            acc_new  = VARINT_BITS'(byte_in & VALUE_BITS_MASK);
        end
        acc_sat = (acc_new > MAX_LEN) ? MAX_LEN : acc_new;
    end

    always_comb
    begin
        phase_next        = phase_reg;
        flag_next         = flag_reg;
        left_next         = left_reg;
        acc_next          = acc_reg;
        payload_left_next = payload_left_reg;
        vsize_next        = vsize_reg;
        push              = 1'b0;
        cmd.status        = ST_OK;
        cmd.has_data      = 1'b0;
        cmd.data          = 8'd0;
        cmd.flag          = flag_reg;
        cmd.len           = acc_reg;
        cmd.vsize         = vsize_reg;
        cmd.len_known     = 1'b0;
        cmd.last          = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    if (left_new == 2'd0)
                    begin
                        cmd.len       = acc_sat;
                        cmd.vsize     = vs_new;
                        cmd.len_known = 1'b1;
                        if (acc_sat == '0)
                        begin
                            // empty frame: one result, then back to flag hunt
                            push              = 1'b1;
                            cmd.last          = 1'b1;
                            phase_next        = PH_FLAG;
                            flag_next         = 8'd0;
                            left_next         = 2'd0;
                            acc_next          = '0;
                            payload_left_next = '0;
                            vsize_next        = VSIZE_NONE;
                        end
                        else
                        begin
                            phase_next        = PH_PAYLOAD;
                            acc_next          = acc_sat;
                            vsize_next        = vs_new;
                            left_next         = 2'd0;
                            payload_left_next = acc_sat[LENGTH_BITS-1:0];
                            if (buffer_end)
                            begin
                                push       = 1'b1;
                                cmd.status = ST_INCOMPLETE;
                            end
                        end
                    end
                    else
                    begin
                        acc_next   = acc_new;
                        vsize_next = vs_new;
                        left_next  = left_new;
                        if (buffer_end)
                        begin
                            push       = 1'b1;
                            cmd.status = ST_INCOMPLETE;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    push          = 1'b1;
                    cmd.status    = (buffer_end && !fin) ? ST_INCOMPLETE : ST_OK;
                    cmd.has_data  = 1'b1;
                    cmd.data      = byte_in;
                    cmd.len_known = 1'b1;
                    cmd.last      = fin;
                    if (fin)
                    begin
                        phase_next        = PH_FLAG;
                        flag_next         = 8'd0;
                        left_next         = 2'd0;
                        acc_next          = '0;
                        payload_left_next = '0;
                        vsize_next        = VSIZE_NONE;
                    end
                    else
                    begin
                        payload_left_next = payload_left_reg - LENGTH_BITS'(1);
                    end
                end
                default:
                begin
                    // flag hunt: start a fresh frame either way
                    left_next         = 2'd0;
                    acc_next          = '0;
                    payload_left_next = '0;
                    vsize_next        = VSIZE_NONE;
                    cmd.flag          = byte_in;
                    if ((byte_in & ~flag_mask) != 8'd0)
                    begin
                        push       = 1'b1;
                        cmd.status = ST_RESERVED;
                        phase_next = PH_FLAG;
                        flag_next  = 8'd0;
                    end
                    else
                    begin
                        phase_next = PH_LENGTH;
                        flag_next  = byte_in;
                        if (buffer_end)
                        begin
                            push       = 1'b1;
                            cmd.status = ST_INCOMPLETE;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_FLAG;
            flag_reg         <= 8'd0;
            left_reg         <= 2'd0;
            acc_reg          <= '0;
            payload_left_reg <= '0;
            vsize_reg        <= VSIZE_NONE;
        end
        else
        begin
            phase_reg        <= phase_next;
            flag_reg         <= flag_next;
            left_reg         <= left_next;
            acc_reg          <= acc_next;
            payload_left_reg <= payload_left_next;
            vsize_reg        <= vsize_next;
        end
    end

`ifndef SYNTHESIS
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> acc_reg != '0 && payload_left_reg != '0
                                    && vsize_reg != VSIZE_NONE)
        else $error("payload phase with empty length");

    a_fresh_length: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LENGTH && vsize_reg == VSIZE_NONE |-> left_reg == 2'd0
                                                             && acc_reg == '0)
        else $error("length decode did not start clean");

    a_reserved_empty: assert property (@(posedge clk) disable iff (!rst_n)
        push && cmd.status == ST_RESERVED |-> !cmd.has_data && !cmd.last
                                              && !cmd.len_known)
        else $error("reserved flag result carries frame data");
`endif

endmodule

// ----- src/vld_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vld_queue: short record queue between parser and output stage
// Two register entries; lets the front keep taking bytes while a result
// waits at the output.
// ============================================================================
module vld_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vld_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          head_valid,
    output vld_pkg::cmd_t head_cmd,
    input  logic          pop
);
    import vld_pkg::*;

    cmd_t       entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'(QUEUE_DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");
`endif

endmodule

// ----- src/vld_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// vld_back: result formatting and output register
// Takes queued records, fills in the frame length fields and holds each
// result until the consumer takes it.
// ============================================================================
module vld_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  vld_pkg::cmd_t                   head_cmd,
    output logic                            pop,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [1:0]                      status,
    output logic                            has_data,
    output logic [7:0]                      data_out,
    output logic [7:0]                      frame_flag,
    output logic [vld_pkg::VARINT_BITS-1:0] payload_length,
    output logic [vld_pkg::CONSUMED_BITS-1:0] consumed_length,
    output logic                            last
);
    import vld_pkg::*;

    logic                     valid_reg, valid_next;
    logic [1:0]               status_reg;
    logic                     has_data_reg;
    logic [7:0]               data_reg;
    logic [7:0]               flag_reg;
    logic [VARINT_BITS-1:0]   plen_reg;
    logic [CONSUMED_BITS-1:0] clen_reg;
    logic                     last_reg;
    logic [CONSUMED_BITS-1:0] total;

    assign pop        = head_valid && (!valid_reg || result_ready);
    assign valid_next = pop || (valid_reg && !result_ready);

    // Flag byte + varint bytes + payload
    assign total = CONSUMED_BITS'(1) + CONSUMED_BITS'(head_cmd.vsize)
                 + CONSUMED_BITS'(head_cmd.len);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg   <= head_cmd.status;
            has_data_reg <= head_cmd.has_data;
            data_reg     <= head_cmd.has_data ? head_cmd.data : 8'd0;
            flag_reg     <= head_cmd.flag;
            plen_reg     <= head_cmd.len_known ? head_cmd.len : '0;
            clen_reg     <= head_cmd.len_known ? total : '0;
            last_reg     <= head_cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign result_valid    = valid_reg;
    assign status          = status_reg;
    assign has_data        = has_data_reg;
    assign data_out        = data_reg;
    assign frame_flag      = flag_reg;
    assign payload_length  = plen_reg;
    assign consumed_length = clen_reg;
    assign last            = last_reg;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the varint length deframer
// Feeds a byte stream of flag / varint length / payload frames through the
// valid-ready input, predicts every result with a behavioral parser of its
// own, and compares each accepted result field by field, under random
// idling on both sides and several flag mask settings.
// ============================================================================
module tb_top;
    import vld_pkg::*;

    // Random stream length, split evenly over the mask phases
    localparam int RANDOM_BYTES      = 1400;
    localparam int N_PHASES          = 6;
    // Directed table: opening rows run after reset, the rest close the run
    localparam int N_OPEN            = 23;
    localparam int N_ROWS            = 31;
    // Give the block room to drain before touching the register
    localparam int SETTLE_CYCLES     = 10;
    // One long receiver hold-off so the output queue fills and input stalls
    localparam int LONG_HOLD_AT      = 400;
    localparam int LONG_HOLD_CYCLES  = 300;

    // One result of the deframer, laid out as the output ports
    typedef struct packed {
        status_t                  status;
        logic                     has_data;
        logic [7:0]               data;
        logic [7:0]               flag;
        logic [VARINT_BITS-1:0]   plen;
        logic [CONSUMED_BITS-1:0] clen;
        logic                     last;
    } frame_result_t;

    // One input item; typed rows carry a hand-written expectation
    typedef struct {
        logic [7:0]    b;
        bit            at_end;
        bit            typed;
        bit            yields;
        frame_result_t want;
    } stim_row_t;

    typedef enum logic [1:0] {
        PS_HUNT,
        PS_LENGTH,
        PS_PAYLOAD
    } parse_state_t;

    logic                     clk;
    logic                     rst_n;
    logic                     flag_mask_we;
    logic [7:0]               flag_mask_data;
    logic                     byte_valid;
    logic                     byte_ready;
    logic [7:0]               byte_in;
    logic                     buffer_end;
    logic                     result_valid;
    logic                     result_ready;
    logic [1:0]               status;
    logic                     has_data;
    logic [7:0]               data_out;
    logic [7:0]               frame_flag;
    logic [VARINT_BITS-1:0]   payload_length;
    logic [CONSUMED_BITS-1:0] consumed_length;
    logic                     last;

    varint_length_deframer u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .flag_mask_we    (flag_mask_we),
        .flag_mask_data  (flag_mask_data),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .byte_in         (byte_in),
        .buffer_end      (buffer_end),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .status          (status),
        .has_data        (has_data),
        .data_out        (data_out),
        .frame_flag      (frame_flag),
        .payload_length  (payload_length),
        .consumed_length (consumed_length),
        .last            (last)
    );

    // ------------------------------------------------------------------------
    // Parser copy: the bench's own view of the frame state and the register
    // ------------------------------------------------------------------------
    logic [7:0]             mask_model;
    parse_state_t           pstate;
    logic [7:0]             open_flag;
    logic [2:0]             len_size;
    logic [2:0]             len_todo;
    logic [VARINT_BITS-1:0] len_val;
    logic [VARINT_BITS-1:0] bytes_to_go;

    // Results still owed by the block, oldest first
    frame_result_t results_due[$];

    stim_row_t   directed[N_ROWS];
    stim_row_t   cur_row;
    int unsigned bytes_offered;
    bit          tx_calm;
    int          errors;

    // Forget the current frame and go back to hunting for a flag byte
    function automatic void start_hunt();
        pstate      = PS_HUNT;
        open_flag   = '0;
        len_size    = VSIZE_NONE;
        len_todo    = '0;
        len_val     = '0;
        bytes_to_go = '0;
    endfunction

    // Advance the parser copy by one byte; return 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b, input bit at_end,
                                        output frame_result_t r);
        logic [CONSUMED_BITS-1:0] total;
        r = '0;
        case (pstate)
            PS_LENGTH:
            begin
                if (len_size == VSIZE_NONE)
                begin
                    // First length byte: prefix picks the form, low six bits
                    // start the value. Both 10 and 11 select four bytes.
                    case (b[7:6])
                        PREFIX_ONE: len_size = VSIZE_ONE;
                        PREFIX_TWO: len_size = VSIZE_TWO;
                        default:    len_size = VSIZE_FOUR;
                    endcase
                    len_val  = VARINT_BITS'(b & VALUE_BITS_MASK);
                    len_todo = len_size - 3'd1;
                end
                else
                begin
                    len_val  = {len_val[VARINT_BITS-9:0], b};
                    len_todo = len_todo - 3'd1;
                end
                if (len_todo != 0)
                begin
                    // Length still open: only a buffer end reports anything
                    if (!at_end)
                        return 1'b0;
                    r.status = ST_INCOMPLETE;
                    r.flag   = open_flag;
                    return 1'b1;
                end
                total = CONSUMED_BITS'(1) + CONSUMED_BITS'(len_size)
                      + CONSUMED_BITS'(len_val);
                if (len_val == 0)
                begin
                    // Empty frame: one result, marked last, regardless of end
                    r.status = ST_OK;
                    r.flag   = open_flag;
                    r.clen   = total;
                    r.last   = 1'b1;
                    start_hunt();
                    return 1'b1;
                end
                pstate      = PS_PAYLOAD;
                bytes_to_go = len_val;
                if (!at_end)
                    return 1'b0;
                r.status = ST_INCOMPLETE;
                r.flag   = open_flag;
                r.plen   = len_val;
                r.clen   = total;
                return 1'b1;
            end
            PS_PAYLOAD:
            begin
                r.last     = (bytes_to_go <= 1);
                r.status   = (at_end && !r.last) ? ST_INCOMPLETE : ST_OK;
                r.has_data = 1'b1;
                r.data     = b;
                r.flag     = open_flag;
                r.plen     = len_val;
                r.clen     = CONSUMED_BITS'(1) + CONSUMED_BITS'(len_size)
                           + CONSUMED_BITS'(len_val);
                if (r.last)
                    start_hunt();
                else
                    bytes_to_go = bytes_to_go - 1'b1;
                return 1'b1;
            end
            default:
            begin
                start_hunt();
                // Reserved bits drop the byte; buffer end plays no part here
                if ((b & ~mask_model) != 0)
                begin
                    r.status = ST_RESERVED;
                    r.flag   = b;
                    return 1'b1;
                end
                pstate    = PS_LENGTH;
                open_flag = b;
                if (!at_end)
                    return 1'b0;
                r.status = ST_INCOMPLETE;
                r.flag   = b;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic frame_result_t res(input status_t st, input logic hd,
                                          input logic [7:0] d,
                                          input logic [7:0] fl,
                                          input logic [VARINT_BITS-1:0] pl,
                                          input logic [CONSUMED_BITS-1:0] cl,
                                          input logic la);
        frame_result_t r;
        r.status   = st;
        r.has_data = hd;
        r.data     = d;
        r.flag     = fl;
        r.plen     = pl;
        r.clen     = cl;
        r.last     = la;
        return r;
    endfunction

    function automatic stim_row_t row(input logic [7:0] b, input bit at_end,
                                      input bit typed, input bit yields,
                                      input frame_result_t want);
        stim_row_t s;
        s.b      = b;
        s.at_end = at_end;
        s.typed  = typed;
        s.yields = yields;
        s.want   = want;
        return s;
    endfunction

    // Random stream byte: buffer end on about one byte in eight
    function automatic stim_row_t stream_row(input logic [7:0] b);
        return row(b, ($urandom_range(0, 7) == 0), 1'b0, 1'b0, '0);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: idle a random number of cycles, then hold the item until taken
    // ------------------------------------------------------------------------
    task automatic offer_byte(input stim_row_t s);
        int unsigned gap;
        // Switch between stretches with no gaps and stretches with random ones
        if (bytes_offered % 40 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        bytes_offered++;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap != 0)
        begin
            byte_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_row    = s;
        byte_in    = s.b;
        buffer_end = s.at_end;
        byte_valid = 1'b1;
        do
            @(posedge clk);
        while (!byte_ready);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline empty
    task automatic settle_idle();
        @(negedge clk);
        byte_valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a result
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall a random number of cycles per result, with one long hold
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned w;
        int unsigned n_taken;
        bit          calm;
        result_ready = 1'b0;
        n_taken      = 0;
        calm         = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (n_taken % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            w = calm ? 0 : $urandom_range(0, 19);
            // Hold off long enough for the queue to fill and the input to stall
            if (n_taken == LONG_HOLD_AT)
                w = LONG_HOLD_CYCLES;
            if (w != 0)
            begin
                @(negedge clk);
                result_ready = 1'b0;
                repeat (w - 1) @(negedge clk);
            end
            @(negedge clk);
            result_ready = 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            n_taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each taken byte, check on each taken result
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        frame_result_t got;
        frame_result_t want;
        bit            yields;
        if (rst_n)
        begin
            if (flag_mask_we)
                mask_model = flag_mask_data;
            if (byte_valid && byte_ready)
            begin
                yields = deframe_byte(byte_in, buffer_end, want);
                // Hand-typed rows override the prediction but still advance it
                if (cur_row.typed)
                begin
                    yields = cur_row.yields;
                    want   = cur_row.want;
                end
                if (yields)
                    results_due.push_back(want);
            end
            if (result_valid && result_ready)
            begin
                got = res(status_t'(status), has_data, data_out, frame_flag,
                          payload_length, consumed_length, last);
                if (results_due.size() == 0)
                begin
                    $error("result with none expected: status %0d flag 0x%0h",
                           got.status, got.flag);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.has_data !== want.has_data)
                    begin
                        $error("has_data: expected %0d, got %0d",
                               want.has_data, got.has_data);
                        errors++;
                    end
                    if (got.data !== want.data)
                    begin
                        $error("data_out: expected 0x%0h, got 0x%0h", want.data, got.data);
                        errors++;
                    end
                    if (got.flag !== want.flag)
                    begin
                        $error("frame_flag: expected 0x%0h, got 0x%0h", want.flag, got.flag);
                        errors++;
                    end
                    if (got.plen !== want.plen)
                    begin
                        $error("payload_length: expected %0d, got %0d", want.plen, got.plen);
                        errors++;
                    end
                    if (got.clen !== want.clen)
                    begin
                        $error("consumed_length: expected %0d, got %0d",
                               want.clen, got.clen);
                        errors++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : main
        logic [7:0]  m;
        logic [7:0]  nb;
        int unsigned len;
        int unsigned sel;
        int unsigned room;

        rst_n          = 1'b0;
        flag_mask_we   = 1'b0;
        flag_mask_data = '0;
        byte_valid     = 1'b0;
        byte_in        = '0;
        buffer_end     = 1'b0;
        cur_row        = row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        bytes_offered  = 0;
        tx_calm        = 1'b0;
        errors         = 0;
        mask_model     = 8'h01;
        start_hunt();

        // Opening rows run with the reset mask of 0x01
        // Empty one-byte-length frame
        directed[0]  = row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        directed[1]  = row(8'h00, 1'b0, 1'b1, 1'b1,
                           res(ST_OK, 1'b0, 8'h00, 8'h00, '0, 31'd2, 1'b1));
        // Reserved flags, the second one with buffer end that must be ignored
        directed[2]  = row(8'hFE, 1'b0, 1'b1, 1'b1,
                           res(ST_RESERVED, 1'b0, 8'h00, 8'hFE, '0, '0, 1'b0));
        directed[3]  = row(8'hFF, 1'b1, 1'b1, 1'b1,
                           res(ST_RESERVED, 1'b0, 8'h00, 8'hFF, '0, '0, 1'b0));
        // Buffer end right on the flag byte, then a one-byte payload that
        // ends together with the buffer
        directed[4]  = row(8'h01, 1'b1, 1'b1, 1'b1,
                           res(ST_INCOMPLETE, 1'b0, 8'h00, 8'h01, '0, '0, 1'b0));
        directed[5]  = row(8'h01, 1'b0, 1'b0, 1'b0, '0);
        directed[6]  = row(8'hFF, 1'b1, 1'b1, 1'b1,
                           res(ST_OK, 1'b1, 8'hFF, 8'h01, 30'd1, 31'd3, 1'b1));
        // Two-byte length with buffer end between its bytes and mid-payload
        directed[7]  = row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        directed[8]  = row(8'h40, 1'b1, 1'b1, 1'b1,
                           res(ST_INCOMPLETE, 1'b0, 8'h00, 8'h00, '0, '0, 1'b0));
        directed[9]  = row(8'h02, 1'b0, 1'b0, 1'b0, '0);
        directed[10] = row(8'h00, 1'b1, 1'b1, 1'b1,
                           res(ST_INCOMPLETE, 1'b1, 8'h00, 8'h00, 30'd2, 31'd5, 1'b0));
        directed[11] = row(8'h5A, 1'b0, 1'b0, 1'b0, '0);
        // Four-byte form (prefix 10), zero length ending with the buffer
        directed[12] = row(8'h01, 1'b0, 1'b0, 1'b0, '0);
        directed[13] = row(8'h80, 1'b0, 1'b0, 1'b0, '0);
        directed[14] = row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        directed[15] = row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        directed[16] = row(8'h00, 1'b1, 1'b1, 1'b1,
                           res(ST_OK, 1'b0, 8'h00, 8'h01, '0, 31'd5, 1'b1));
        // Four-byte form through prefix 11, buffer end on the last length byte
        directed[17] = row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        directed[18] = row(8'hC0, 1'b0, 1'b0, 1'b0, '0);
        directed[19] = row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        directed[20] = row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        directed[21] = row(8'h01, 1'b1, 1'b1, 1'b1,
                           res(ST_INCOMPLETE, 1'b0, 8'h00, 8'h00, 30'd1, 31'd6, 1'b0));
        directed[22] = row(8'hA5, 1'b0, 1'b0, 1'b0, '0);
        // Closing rows: largest length, which can never finish, so it goes last
        directed[23] = row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        directed[24] = row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
        directed[25] = row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
        directed[26] = row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
        directed[27] = row(8'hFF, 1'b1, 1'b1, 1'b1,
                           res(ST_INCOMPLETE, 1'b0, 8'h00, 8'h00,
                               30'h3FFF_FFFF, 31'h4000_0004, 1'b0));
        directed[28] = row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        directed[29] = row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
        directed[30] = row(8'h5A, 1'b1, 1'b0, 1'b0, '0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_OPEN; i++)
            offer_byte(directed[i]);

        // Random frames, one mask per phase; extremes first
        for (int p = 0; p < N_PHASES; p++)
        begin
            settle_idle();
            case (p)
                0:       m = 8'hFF;
                1:       m = 8'h00;
                default: m = 8'($urandom_range(1, 254));
            endcase
            @(negedge clk);
            flag_mask_we   = 1'b1;
            flag_mask_data = m;
            @(negedge clk);
            flag_mask_we   = 1'b0;

            while (bytes_offered < N_OPEN + (p + 1) * RANDOM_BYTES / N_PHASES)
            begin
                if (m != 8'hFF && $urandom_range(0, 5) == 0)
                begin
                    // Noise: a flag byte with at least one reserved bit
                    do
                        nb = 8'($urandom_range(0, 255));
                    while ((nb & ~m) == 0);
                    offer_byte(stream_row(nb));
                end
                else
                begin
                    offer_byte(stream_row(8'($urandom_range(0, 255)) & m));
                    // Bytes left in this phase's share
                    room = N_OPEN + (p + 1) * RANDOM_BYTES / N_PHASES - bytes_offered;
                    sel = $urandom_range(0, 9);
                    // Keep most lengths short; now and then up to 511
                    if ($urandom_range(0, 3) == 0)
                        len = $urandom_range(0, 511);
                    else
                        len = $urandom_range(0, 40);
                    // Trim the payload so the phase ends near its share
                    if (len > room)
                        len = room;
                    if (sel < 7)
                    begin
                        len = len % 64;
                        if ($urandom_range(0, 7) == 0)
                            len = 0;
                        offer_byte(stream_row(8'(len)));
                    end
                    else if (sel < 9)
                    begin
                        offer_byte(stream_row(8'h40 | 8'(len >> 8)));
                        offer_byte(stream_row(8'(len)));
                    end
                    else
                    begin
                        nb = ($urandom_range(0, 1) == 0) ? {PREFIX_FOUR, 6'd0}
                                                         : {PREFIX_FOUR_ALT, 6'd0};
                        offer_byte(stream_row(nb));
                        offer_byte(stream_row(8'h00));
                        offer_byte(stream_row(8'(len >> 8)));
                        offer_byte(stream_row(8'(len)));
                    end
                    repeat (len) offer_byte(stream_row(8'($urandom_range(0, 255))));
                end
            end
        end

        settle_idle();
        for (int i = N_OPEN; i < N_ROWS; i++)
            offer_byte(directed[i]);
        settle_idle();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
